@@ rtl/core/cau_pkg.sv @@
// Shared types, constants and helpers for the complex arithmetic unit.
package cau_pkg;

  localparam int DataWidth   = 16;
  localparam int FracBits    = 8;
  localparam int MaxExponent = 15;
  localparam int ProdWidth   = 2 * DataWidth + 2;
  localparam int NumWidth    = ProdWidth + FracBits + 1;
  localparam int DenWidth    = 2 * DataWidth + 1;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef enum logic [3:0] {
    CmdAdd  = 4'd0,
    CmdSub  = 4'd1,
    CmdMul  = 4'd2,
    CmdDiv  = 4'd3,
    CmdConj = 4'd4,
    CmdNeg  = 4'd5,
    CmdMag  = 4'd6,
    CmdPow  = 4'd7,
    CmdCmp  = 4'd8
  } cmd_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpSimple,
    OpMulRe,
    OpMulIm,
    OpDivSetup,
    OpDivStep,
    OpSqrtStep
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       pow_acc;
    logic       div_im;
    logic [5:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] exponent;
    logic       den_zero;
  } dp_status_t;

  function automatic logic signed [DataWidth-1:0] sat_wide(
    input logic signed [NumWidth-1:0] v, output logic flag);
    logic signed [NumWidth-1:0] mx;
    logic signed [NumWidth-1:0] mn;
    mx = NumWidth'((64'sd1 <<< (DataWidth - 1)) - 64'sd1);
    mn = -mx - NumWidth'(1);
    flag = 1'b0;
    if (v > mx) begin
      flag = 1'b1;
      return mx[DataWidth-1:0];
    end
    if (v < mn) begin
      flag = 1'b1;
      return mn[DataWidth-1:0];
    end
    return v[DataWidth-1:0];
  endfunction

endpackage

@@ rtl/core/cau_datapath.sv @@
// Datapath: operand registers, shared multiplier, restoring divider and root unit.
module cau_datapath (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [3:0]           cmd_i,
  input  cau_pkg::data_t       a_re_i,
  input  cau_pkg::data_t       a_im_i,
  input  cau_pkg::data_t       b_re_i,
  input  cau_pkg::data_t       b_im_i,
  input  logic [3:0]           exponent_i,
  input  cau_pkg::dp_cmd_t     dp_cmd_i,
  output cau_pkg::dp_status_t  status_o,
  output cau_pkg::data_t       res_re_o,
  output cau_pkg::data_t       res_im_o,
  output logic                 div_zero_o,
  output logic                 saturated_o,
  output logic                 is_equal_o,
  output logic                 is_less_o,
  output logic                 is_greater_o
);
  import cau_pkg::*;

  localparam int SqW = 2 * DataWidth + 1;

  logic [3:0] cmd_q;
  logic [3:0] exp_q;
  data_t ar_q, ai_q, br_q, bi_q;
  data_t pr_q, pi_q;          // running power / multiply operand x
  data_t rr_q, rr_d, ri_q, ri_d;
  logic  dz_q, dz_d, st_q, st_d, eq_q, eq_d, lt_q, lt_d, gt_q, gt_d;
  logic [DenWidth-1:0] den_q;
  logic [NumWidth-1:0] rem_q, quo_q;
  logic                neg_q;
  logic signed [NumWidth-1:0] numim_q;
  logic [SqW-1:0] sn_q, sroot_q;

  // Two multiplies per cycle on 16-bit operands; sum registered in the result path.
  logic signed [ProdWidth-1:0] p0, p1, psum, rnd;
  logic signed [NumWidth-1:0]  scaled;
  logic                        sflag;
  data_t                       sres;
  logic                        aflag0, aflag1;
  data_t                       ares0, ares1;

  always_comb begin
    data_t x0, y0, x1, y1;
    logic  sub;
    x0 = pr_q; y0 = br_q; x1 = pi_q; y1 = bi_q; sub = 1'b1;
    if (dp_cmd_i.pow_acc) begin
      y0 = ar_q; y1 = ai_q;
    end
    if (dp_cmd_i.op == OpMulIm) begin
      x0 = pr_q; x1 = pi_q; sub = 1'b0;
      y0 = dp_cmd_i.pow_acc ? ai_q : bi_q;
      y1 = dp_cmd_i.pow_acc ? ar_q : br_q;
    end
    p0 = ProdWidth'(x0) * ProdWidth'(y0);
    p1 = ProdWidth'(x1) * ProdWidth'(y1);
    psum = sub ? p0 - p1 : p0 + p1;
    rnd  = psum + ProdWidth'((FracBits > 0) ? (1 << (FracBits - 1)) : 0);
    scaled = NumWidth'(rnd >>> FracBits);
    sres = sat_wide(scaled, sflag);
  end

  // Add, subtract, conjugate, negate.
  always_comb begin
    logic signed [NumWidth-1:0] s0, s1;
    case (cmd_q)
      CmdAdd: begin
        s0 = NumWidth'(ar_q) + NumWidth'(br_q);
        s1 = NumWidth'(ai_q) + NumWidth'(bi_q);
      end
      CmdSub: begin
        s0 = NumWidth'(ar_q) - NumWidth'(br_q);
        s1 = NumWidth'(ai_q) - NumWidth'(bi_q);
      end
      CmdConj: begin
        s0 = NumWidth'(ar_q);
        s1 = -NumWidth'(ai_q);
      end
      CmdNeg: begin
        s0 = -NumWidth'(ar_q);
        s1 = -NumWidth'(ai_q);
      end
      default: begin
        s0 = '0;
        s1 = '0;
      end
    endcase
    ares0 = sat_wide(s0, aflag0);
    ares1 = sat_wide(s1, aflag1);
  end

  // Divider step: one quotient bit per cycle from the MSB of the magnitude.
  logic [NumWidth-1:0] rem_sh, quo_n;
  logic [NumWidth-1:0] rem_n;
  always_comb begin
    rem_sh = {rem_q[NumWidth-2:0], quo_q[NumWidth-1]};
    quo_n  = {quo_q[NumWidth-2:0], 1'b0};
    rem_n  = rem_sh;
    if (rem_sh >= NumWidth'(den_q)) begin
      rem_n = rem_sh - NumWidth'(den_q);
      quo_n[0] = 1'b1;
    end
  end

  // Root step: one result bit per cycle, bit position 2*(15-step).
  logic [SqW-1:0] sbit, stry;
  always_comb begin
    sbit = SqW'(1) << (2 * (DataWidth - 1 - int'(dp_cmd_i.step[3:0])));
    stry = sroot_q + sbit;
  end

  logic [SqW-1:0] mag_a, mag_b;
  always_comb begin
    mag_a = SqW'(2 * DataWidth'(0)) + SqW'($unsigned(
              (2*DataWidth)'(ar_q) * (2*DataWidth)'(ar_q)))
            + SqW'($unsigned((2*DataWidth)'(ai_q) * (2*DataWidth)'(ai_q)));
    mag_b = SqW'($unsigned((2*DataWidth)'(br_q) * (2*DataWidth)'(br_q)))
            + SqW'($unsigned((2*DataWidth)'(bi_q) * (2*DataWidth)'(bi_q)));
  end

  // Divider setup numerators; products stay at operand-pair width, then extend.
  logic signed [NumWidth-1:0] num_re, num_im, num_sel;
  always_comb begin
    logic signed [2*DataWidth-1:0] m_rr, m_ii, m_ir, m_ri;
    m_rr = (2*DataWidth)'(ar_q) * (2*DataWidth)'(br_q);
    m_ii = (2*DataWidth)'(ai_q) * (2*DataWidth)'(bi_q);
    m_ir = (2*DataWidth)'(ai_q) * (2*DataWidth)'(br_q);
    m_ri = (2*DataWidth)'(ar_q) * (2*DataWidth)'(bi_q);
    num_re = (NumWidth'(m_rr) + NumWidth'(m_ii)) <<< FracBits;
    num_im = (NumWidth'(m_ir) - NumWidth'(m_ri)) <<< FracBits;
    num_sel = dp_cmd_i.div_im ? numim_q : num_re;
  end

  logic               dflag;
  data_t              dres;
  logic signed [NumWidth-1:0] dq;
  always_comb begin
    dq = neg_q ? -$signed(quo_n) : $signed(quo_n);
    dres = sat_wide(dq, dflag);
  end

  always_comb begin
    logic pflag;
    pflag = 1'b0;
    rr_d = rr_q; ri_d = ri_q; dz_d = dz_q; st_d = st_q;
    eq_d = eq_q; lt_d = lt_q; gt_d = gt_q;
    case (dp_cmd_i.op)
      OpLoad: begin
        rr_d = '0; ri_d = '0; dz_d = 1'b0; st_d = 1'b0;
        eq_d = 1'b0; lt_d = 1'b0; gt_d = 1'b0;
      end
      OpSimple: begin
        if (cmd_q == CmdCmp) begin
          eq_d = (ar_q == br_q) && (ai_q == bi_q);
          lt_d = mag_a < mag_b;
          gt_d = mag_a > mag_b;
        end else if (cmd_q == CmdPow) begin
          if (exp_q == 4'd0) begin
            rr_d = sat_wide(NumWidth'(1) <<< FracBits, pflag);
            st_d = pflag;
          end else begin
            rr_d = ar_q; ri_d = ai_q;
          end
        end else if (cmd_q == CmdDiv) begin
          dz_d = (mag_b == '0);
        end else if (cmd_q inside {CmdAdd, CmdSub, CmdConj, CmdNeg}) begin
          rr_d = ares0; ri_d = ares1;
          st_d = (aflag0 && cmd_q != CmdConj) || aflag1;
        end
      end
      OpMulRe: begin
        rr_d = sres;
        st_d = st_q | sflag;
      end
      OpMulIm: begin
        ri_d = sres;
        st_d = st_q | sflag;
      end
      OpDivStep: begin
        if (dp_cmd_i.step == 6'(NumWidth - 1)) begin
          if (dp_cmd_i.div_im) ri_d = dres;
          else rr_d = dres;
          st_d = st_q | dflag;
        end
      end
      OpSqrtStep: begin
        if (dp_cmd_i.step == 6'(DataWidth - 1)) begin
          rr_d = sat_wide(NumWidth'(sn_q >= stry ? (sroot_q >> 1) + sbit
                                                  : sroot_q >> 1), pflag);
          st_d = pflag;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q <= cmd_i;
      exp_q <= (exponent_i > 4'(MaxExponent)) ? 4'(MaxExponent) : exponent_i;
      ar_q <= a_re_i; ai_q <= a_im_i; br_q <= b_re_i; bi_q <= b_im_i;
      pr_q <= a_re_i; pi_q <= a_im_i;
    end
    rr_q <= rr_d; ri_q <= ri_d; dz_q <= dz_d; st_q <= st_d;
    eq_q <= eq_d; lt_q <= lt_d; gt_q <= gt_d;
    if (dp_cmd_i.op == OpMulIm && dp_cmd_i.pow_acc) begin
      pr_q <= rr_q; pi_q <= sres;
    end
    if (dp_cmd_i.op == OpDivSetup) begin
      den_q   <= DenWidth'(mag_b);
      numim_q <= num_im;
      neg_q   <= num_sel[NumWidth-1];
      quo_q   <= num_sel[NumWidth-1] ? NumWidth'(-num_sel) : NumWidth'(num_sel);
      rem_q   <= '0;
      sn_q    <= mag_a;
      sroot_q <= '0;
    end
    if (dp_cmd_i.op == OpDivStep) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
    if (dp_cmd_i.op == OpSqrtStep) begin
      if (sn_q >= stry) begin
        sn_q    <= sn_q - stry;
        sroot_q <= (sroot_q >> 1) + sbit;
      end else begin
        sroot_q <= sroot_q >> 1;
      end
    end
  end

  assign status_o.cmd      = cmd_q;
  assign status_o.exponent = exp_q;
  assign status_o.den_zero = (mag_b == '0);

  assign res_re_o     = rr_q;
  assign res_im_o     = ri_q;
  assign div_zero_o   = dz_q;
  assign saturated_o  = st_q;
  assign is_equal_o   = eq_q;
  assign is_less_o    = lt_q;
  assign is_greater_o = gt_q;

endmodule

@@ rtl/core/cau_ctrl.sv @@
// Controller: sequences datapath steps for each command and runs the handshake.
module cau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cau_pkg::dp_status_t status_i,
  output cau_pkg::dp_cmd_t    dp_cmd_o
);
  import cau_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StFirst, StMulRe, StMulIm, StDivSetup, StDivStep, StSqrtSetup,
    StSqrtStep, StDone
  } state_e;

  state_e     state_q;
  logic [5:0] step_q;
  logic       im_q;
  logic [3:0] cnt_q;

  always_comb begin
    dp_cmd_o = '{op: OpNone, pow_acc: 1'b0, div_im: im_q, step: step_q};
    case (state_q)
      StIdle:      if (in_valid_i) dp_cmd_o.op = OpLoad;
      StFirst:     dp_cmd_o.op = OpSimple;
      StMulRe: begin
        dp_cmd_o.op = OpMulRe;
        dp_cmd_o.pow_acc = (status_i.cmd == CmdPow);
      end
      StMulIm: begin
        dp_cmd_o.op = OpMulIm;
        dp_cmd_o.pow_acc = (status_i.cmd == CmdPow);
      end
      StDivSetup, StSqrtSetup: dp_cmd_o.op = OpDivSetup;
      StDivStep:   dp_cmd_o.op = OpDivStep;
      StSqrtStep:  dp_cmd_o.op = OpSqrtStep;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      im_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StFirst;
        StFirst: begin
          step_q <= '0;
          im_q   <= 1'b0;
          cnt_q  <= 4'd1;
          case (status_i.cmd)
            CmdMul: state_q <= StMulRe;
            CmdDiv: state_q <= status_i.den_zero ? StDone : StDivSetup;
            CmdMag: state_q <= StSqrtSetup;
            CmdPow: state_q <= (status_i.exponent > 4'd1) ? StMulRe : StDone;
            default: state_q <= StDone;
          endcase
        end
        StMulRe: state_q <= StMulIm;
        StMulIm: begin
          if (status_i.cmd == CmdPow && cnt_q + 4'd1 < status_i.exponent) begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= StMulRe;
          end else begin
            state_q <= StDone;
          end
        end
        StDivSetup: begin
          step_q  <= '0;
          state_q <= StDivStep;
        end
        StDivStep: begin
          if (step_q == 6'(NumWidth - 1)) begin
            if (im_q) begin
              state_q <= StDone;
            end else begin
              im_q    <= 1'b1;
              state_q <= StDivSetup;
            end
          end else begin
            step_q <= step_q + 6'd1;
          end
        end
        StSqrtSetup: begin
          step_q  <= '0;
          state_q <= StSqrtStep;
        end
        StSqrtStep: begin
          if (step_q == 6'(DataWidth - 1)) state_q <= StDone;
          else step_q <= step_q + 6'd1;
        end
        StDone: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/core/complex_arithmetic_unit.sv @@
// Top level of the fixed-point complex arithmetic unit.
// One item is in flight at a time. Add, subtract, conjugate, negate, compare,
// unused codes, divide by a zero divisor and power with n below 2 finish after
// the first step; multiply runs a real and an imaginary step; power repeats
// them n-1 times; magnitude runs 16 root steps, one root bit per cycle; divide
// runs two restoring divisions, one quotient bit a cycle, 43 bits each. The
// result holds on the master side until it is taken; the next item is accepted
// in the cycle after the result transfer.
module complex_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[3:0], a_re[19:4], a_im[35:20], b_re[51:36], b_im[67:52], exponent[71:68]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_re[15:0], res_im[31:16], div_zero[32], saturated[33], is_equal[34],
  // is_less[35], is_greater[36], zero fill above
  output logic [39:0] m_axis_tdata
);
  import cau_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t status;
  data_t      res_re, res_im;
  logic       dz, st, eq, lt, gt;

  cau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .dp_cmd_o    (dp_cmd)
  );

  // Load operands on the input transfer.
  cau_datapath u_dp (
    .clk_i        (clk_i),
    .load_i       (s_axis_tvalid & s_axis_tready),
    .cmd_i        (s_axis_tdata[3:0]),
    .a_re_i       (s_axis_tdata[19:4]),
    .a_im_i       (s_axis_tdata[35:20]),
    .b_re_i       (s_axis_tdata[51:36]),
    .b_im_i       (s_axis_tdata[67:52]),
    .exponent_i   (s_axis_tdata[71:68]),
    .dp_cmd_i     (dp_cmd),
    .status_o     (status),
    .res_re_o     (res_re),
    .res_im_o     (res_im),
    .div_zero_o   (dz),
    .saturated_o  (st),
    .is_equal_o   (eq),
    .is_less_o    (lt),
    .is_greater_o (gt)
  );

  assign m_axis_tdata = {3'b000, gt, lt, eq, st, dz, res_im, res_re};

endmodule
